>>> src/analog_mux_scanner_deadband_top_macros.svh
// Assertion shorthands used by the checker file of this block.
// Each macro samples on clk_i and is disabled while rst_ni is low.
`ifndef ANALOG_MUX_SCANNER_DEADBAND_TOP_MACROS_SVH
`define ANALOG_MUX_SCANNER_DEADBAND_TOP_MACROS_SVH

// Consequent checked in the same cycle as the antecedent.
`define AMSD_ASSERT_NOW(label, ante, cons, msg) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error(msg);

// Consequent checked in the cycle after the antecedent.
`define AMSD_ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error(msg);

`endif

>>> src/amsd_pkg.sv
package amsd_pkg;

  localparam int unsigned CHANNELS_DEF = 16;
  localparam int unsigned ADC_BITS_DEF = 10;

  localparam int unsigned VALUE_BITS = 7;
  localparam int unsigned LOW_LEVEL  = 64;

  localparam int unsigned CFG_IDX_W  = 4;
  localparam int unsigned CFG_DATA_W = 16;
  localparam int unsigned COUNT_W    = 5;
  localparam int unsigned MASK_W     = 16;
  localparam int unsigned CHSEL_W    = 4;
  localparam int unsigned DEADBAND_W = 8;

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_MUX1_COUNT = 4'd0,
    CFG_MUX2_COUNT = 4'd1,
    CFG_MUX1_MASK  = 4'd2,
    CFG_MUX2_MASK  = 4'd3,
    CFG_MODE_CH    = 4'd4,
    CFG_LFO_LEFT   = 4'd5,
    CFG_LFO_RIGHT  = 4'd6,
    CFG_DEADBAND   = 4'd7
  } cfg_idx_e;

  typedef enum logic [1:0] {
    LFO_LEFT   = 2'd0,
    LFO_MIDDLE = 2'd1,
    LFO_RIGHT  = 2'd2
  } lfo_sel_e;

  typedef struct packed {
    logic [COUNT_W-1:0]    mux1_count;
    logic [COUNT_W-1:0]    mux2_count;
    logic [MASK_W-1:0]     mux1_mask;
    logic [MASK_W-1:0]     mux2_mask;
    logic [CHSEL_W-1:0]    mode_ch;
    logic [CHSEL_W-1:0]    lfo_left_ch;
    logic [CHSEL_W-1:0]    lfo_right_ch;
    logic [DEADBAND_W-1:0] deadband;
  } cfg_t;

  localparam cfg_t CFG_RESET = '{
    mux1_count:   COUNT_W'(16),
    mux2_count:   COUNT_W'(16),
    mux1_mask:    '0,
    mux2_mask:    '0,
    mode_ch:      CHSEL_W'(4),
    lfo_left_ch:  CHSEL_W'(5),
    lfo_right_ch: CHSEL_W'(6),
    deadband:     DEADBAND_W'(7)
  };

  // Switch state carried from step to step.
  typedef struct packed {
    logic     lfo_left;
    logic     lfo_right;
    logic     synth_mode;
    lfo_sel_e lfo_sel;
  } mode_state_t;

  localparam mode_state_t MODE_RESET = '{
    lfo_left:   1'b0,
    lfo_right:  1'b0,
    synth_mode: 1'b0,
    lfo_sel:    LFO_MIDDLE
  };

  // Write enables for the two last-value stores.
  typedef struct packed {
    logic first_we;
    logic second_we;
  } store_wr_t;

  typedef struct packed {
    logic [CHSEL_W-1:0]    scanned_channel;
    logic [CHSEL_W-1:0]    next_address;
    logic                  first_event_valid;
    logic [VALUE_BITS-1:0] first_event_value;
    logic                  second_event_valid;
    logic [VALUE_BITS-1:0] second_event_value;
    logic                  synth_mode_out;
    lfo_sel_e              lfo_select_out;
  } result_t;

endpackage

>>> src/amsd_if.sv
interface amsd_cfg_if import amsd_pkg::*;;
  logic                  valid;
  logic                  ready;
  logic [CFG_IDX_W-1:0]  index;
  logic [CFG_DATA_W-1:0] data;

  modport source (output valid, output index, output data, input ready);
  modport sink (input valid, input index, input data, output ready);
endinterface

interface amsd_req_if import amsd_pkg::*; #(
  parameter int unsigned ADC_BITS = ADC_BITS_DEF
);
  logic                valid;
  logic                ready;
  logic [ADC_BITS-1:0] adc_first;
  logic [ADC_BITS-1:0] adc_second;

  modport source (output valid, output adc_first, output adc_second, input ready);
  modport sink (input valid, input adc_first, input adc_second, output ready);
endinterface

interface amsd_res_if import amsd_pkg::*;;
  logic                  valid;
  logic                  ready;
  logic [CHSEL_W-1:0]    scanned_channel;
  logic [CHSEL_W-1:0]    next_address;
  logic                  first_event_valid;
  logic [VALUE_BITS-1:0] first_event_value;
  logic                  second_event_valid;
  logic [VALUE_BITS-1:0] second_event_value;
  logic                  synth_mode_out;
  logic [1:0]            lfo_select_out;

  modport source (
    output valid, output scanned_channel, output next_address,
    output first_event_valid, output first_event_value,
    output second_event_valid, output second_event_value,
    output synth_mode_out, output lfo_select_out,
    input ready
  );
  modport sink (
    input valid, input scanned_channel, input next_address,
    input first_event_valid, input first_event_value,
    input second_event_valid, input second_event_value,
    input synth_mode_out, input lfo_select_out,
    output ready
  );
endinterface

>>> src/amsd_cfg_regs.sv
module amsd_cfg_regs import amsd_pkg::*; (
  input  logic       clk_i,
  input  logic       rst_ni,
  amsd_cfg_if.sink   cfg_i,
  output cfg_t       cfg_o
);

  cfg_t cfg_q, cfg_d;

  assign cfg_i.ready = 1'b1;
  assign cfg_o       = cfg_q;

  always_comb begin
    cfg_d = cfg_q;
    if (cfg_i.valid) begin
      unique case (cfg_idx_e'(cfg_i.index))
        CFG_MUX1_COUNT: cfg_d.mux1_count   = cfg_i.data[COUNT_W-1:0];
        CFG_MUX2_COUNT: cfg_d.mux2_count   = cfg_i.data[COUNT_W-1:0];
        CFG_MUX1_MASK:  cfg_d.mux1_mask    = cfg_i.data[MASK_W-1:0];
        CFG_MUX2_MASK:  cfg_d.mux2_mask    = cfg_i.data[MASK_W-1:0];
        CFG_MODE_CH:    cfg_d.mode_ch      = cfg_i.data[CHSEL_W-1:0];
        CFG_LFO_LEFT:   cfg_d.lfo_left_ch  = cfg_i.data[CHSEL_W-1:0];
        CFG_LFO_RIGHT:  cfg_d.lfo_right_ch = cfg_i.data[CHSEL_W-1:0];
        CFG_DEADBAND:   cfg_d.deadband     = cfg_i.data[DEADBAND_W-1:0];
        default:        cfg_d = cfg_q;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q <= CFG_RESET;
    end else begin
      cfg_q <= cfg_d;
    end
  end

endmodule

>>> src/amsd_step.sv
module amsd_step import amsd_pkg::*; #(
  parameter int unsigned CHANNELS = CHANNELS_DEF,
  parameter int unsigned ADC_BITS = ADC_BITS_DEF,
  localparam int unsigned CH_W    = $clog2(CHANNELS)
) (
  input  cfg_t                cfg_i,
  input  logic [CH_W-1:0]     ch_i,
  input  logic [ADC_BITS-1:0] adc_first_i,
  input  logic [ADC_BITS-1:0] adc_second_i,
  input  logic [ADC_BITS-1:0] first_last_i,
  input  logic [ADC_BITS-1:0] second_last_i,
  input  mode_state_t         mode_i,
  output mode_state_t         mode_o,
  output store_wr_t           store_wr_o,
  output logic [CH_W-1:0]     next_ch_o,
  output result_t             res_o
);

  localparam int unsigned CNT_BITS = $clog2(CHANNELS + 1);
  localparam int unsigned CW = (CNT_BITS > COUNT_W) ? CNT_BITS : COUNT_W;
  localparam int unsigned EW = (CH_W > CHSEL_W) ? CH_W : CHSEL_W;

  logic [CW-1:0]         count1, count2, ch_c, nxt;
  logic [EW-1:0]         ch_e, next_e;
  logic [ADC_BITS-1:0]   diff1, diff2;
  logic                  take1, take2, low1, mask1_ok, mask2_ok;
  logic [VALUE_BITS-1:0] val1, val2;

  // Effective channel counts: mux one is clamped to [1, CHANNELS], mux two
  // to [0, CHANNELS].
  always_comb begin
    count1 = CW'(cfg_i.mux1_count);
    if (count1 == '0) count1 = CW'(1);
    if (count1 > CW'(CHANNELS)) count1 = CW'(CHANNELS);
    count2 = CW'(cfg_i.mux2_count);
    if (count2 > CW'(CHANNELS)) count2 = CW'(CHANNELS);
  end

  assign ch_c = CW'(ch_i);
  assign ch_e = EW'(ch_i);

  assign diff1 = (adc_first_i > first_last_i) ? adc_first_i - first_last_i
                                              : first_last_i - adc_first_i;
  assign diff2 = (adc_second_i > second_last_i) ? adc_second_i - second_last_i
                                                : second_last_i - adc_second_i;

  assign take1 = (ch_c < count1) && (diff1 > ADC_BITS'(cfg_i.deadband));
  assign take2 = (ch_c < count2) && (diff2 > ADC_BITS'(cfg_i.deadband));

  assign val1 = adc_first_i[ADC_BITS-1 -: VALUE_BITS];
  assign val2 = adc_second_i[ADC_BITS-1 -: VALUE_BITS];
  assign low1 = val1 < VALUE_BITS'(LOW_LEVEL);

  // Only the first sixteen channels have a mask bit.
  assign mask1_ok = ((ch_e >> CHSEL_W) == '0) && cfg_i.mux1_mask[ch_e[CHSEL_W-1:0]];
  assign mask2_ok = ((ch_e >> CHSEL_W) == '0) && cfg_i.mux2_mask[ch_e[CHSEL_W-1:0]];

  assign store_wr_o.first_we  = take1;
  assign store_wr_o.second_we = take2;

  always_comb begin
    mode_o = mode_i;
    res_o  = '0;
    if (take1) begin
      if (ch_e == EW'(cfg_i.mode_ch)) begin
        mode_o.synth_mode = low1;
      end else if (ch_e == EW'(cfg_i.lfo_left_ch)) begin
        mode_o.lfo_left = low1;
      end else if (ch_e == EW'(cfg_i.lfo_right_ch)) begin
        mode_o.lfo_right = low1;
      end else if (mask1_ok) begin
        res_o.first_event_valid = 1'b1;
        res_o.first_event_value = val1;
      end
      if (mode_o.lfo_left && !mode_o.lfo_right) begin
        mode_o.lfo_sel = LFO_LEFT;
      end else if (!mode_o.lfo_left && mode_o.lfo_right) begin
        mode_o.lfo_sel = LFO_RIGHT;
      end else begin
        mode_o.lfo_sel = LFO_MIDDLE;
      end
    end
    if (take2 && mask2_ok) begin
      res_o.second_event_valid = 1'b1;
      res_o.second_event_value = val2;
    end
    res_o.scanned_channel = ch_e[CHSEL_W-1:0];
    res_o.next_address    = next_e[CHSEL_W-1:0];
    res_o.synth_mode_out  = mode_o.synth_mode;
    res_o.lfo_select_out  = mode_o.lfo_sel;
  end

  always_comb begin
    nxt = ch_c + CW'(1);
    if (nxt >= count1) nxt = '0;
  end

  assign next_ch_o = CH_W'(nxt);
  assign next_e    = EW'(next_ch_o);

endmodule

>>> src/analog_mux_scanner_deadband_top.sv
// Two-mux analog scanner with a deadband filter on every channel.
// Channels: cfg_i writes one configuration register per request (index and
// data, always ready); req_i carries one scan step, the two converter readings
// taken at the channel the block currently addresses; res_o returns one result
// per step: the scanned channel, the mux address for the next step, the event
// flags and 7-bit values of both muxes, and the synth mode and LFO select.
// Path: an accepted request is captured in the input register, processed from
// there, and its result is captured in the result register.
// Throughput: one request per cycle unless res_o stalls. The whole step is a
// deadband compare and a store update per mux and a role decode for mux one
// between the input register and the result register, so nothing iterates.
// Stall: while res_o is held off, the result register keeps its value and one
// more request can wait in the input register; req_i.ready drops only when
// both are full and the receiver does not take the result.
// Reset: the scan starts at channel 0, both last-value stores read zero, the
// switch flags and valid flags clear and the LFO select sits in the middle
// position. Configuration must be written only while idle; nothing checks it.
module analog_mux_scanner_deadband_top import amsd_pkg::*; #(
  parameter int unsigned CHANNELS = CHANNELS_DEF,
  parameter int unsigned ADC_BITS = ADC_BITS_DEF
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  amsd_cfg_if.sink    cfg_i,
  amsd_req_if.sink    req_i,
  amsd_res_if.source  res_o
);

  localparam int unsigned CH_W = $clog2(CHANNELS);

  cfg_t cfg;

  // Input register.
  logic                req_valid_q;
  logic [ADC_BITS-1:0] adc_first_q, adc_second_q;

  // Scan state.
  logic [CH_W-1:0]     ch_q;
  logic [ADC_BITS-1:0] first_last_q [CHANNELS];
  logic [ADC_BITS-1:0] second_last_q [CHANNELS];
  mode_state_t         mode_q;

  // Step outputs.
  mode_state_t         mode_d;
  store_wr_t           store_wr;
  logic [CH_W-1:0]     ch_d;
  result_t             res_d;

  // Result register.
  logic    res_valid_q;
  result_t res_q;

  logic advance;

  amsd_cfg_regs u_cfg_regs (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .cfg_i  (cfg_i),
    .cfg_o  (cfg)
  );

  amsd_step #(
    .CHANNELS (CHANNELS),
    .ADC_BITS (ADC_BITS)
  ) u_step (
    .cfg_i         (cfg),
    .ch_i          (ch_q),
    .adc_first_i   (adc_first_q),
    .adc_second_i  (adc_second_q),
    .first_last_i  (first_last_q[ch_q]),
    .second_last_i (second_last_q[ch_q]),
    .mode_i        (mode_q),
    .mode_o        (mode_d),
    .store_wr_o    (store_wr),
    .next_ch_o     (ch_d),
    .res_o         (res_d)
  );

  // The registered request is processed when the result register is free or
  // is being emptied at this same edge.
  assign advance     = req_valid_q && (!res_valid_q || res_o.ready);
  assign req_i.ready = !req_valid_q || advance;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      req_valid_q <= 1'b0;
    end else if (req_i.ready) begin
      req_valid_q <= req_i.valid;
    end
  end

  always_ff @(posedge clk_i) begin
    if (req_i.valid && req_i.ready) begin
      adc_first_q  <= req_i.adc_first;
      adc_second_q <= req_i.adc_second;
    end
  end

  // Scan state moves only when a step completes, so the next request always
  // sees what the previous one left behind.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      ch_q   <= '0;
      mode_q <= MODE_RESET;
      for (int i = 0; i < int'(CHANNELS); i++) begin
        first_last_q[i]  <= '0;
        second_last_q[i] <= '0;
      end
    end else if (advance) begin
      ch_q   <= ch_d;
      mode_q <= mode_d;
      if (store_wr.first_we) begin
        first_last_q[ch_q] <= adc_first_q;
      end
      if (store_wr.second_we) begin
        second_last_q[ch_q] <= adc_second_q;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      res_valid_q <= 1'b0;
    end else if (advance) begin
      res_valid_q <= 1'b1;
    end else if (res_o.ready) begin
      res_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (advance) begin
      res_q <= res_d;
    end
  end

  assign res_o.valid              = res_valid_q;
  assign res_o.scanned_channel    = res_q.scanned_channel;
  assign res_o.next_address       = res_q.next_address;
  assign res_o.first_event_valid  = res_q.first_event_valid;
  assign res_o.first_event_value  = res_q.first_event_value;
  assign res_o.second_event_valid = res_q.second_event_valid;
  assign res_o.second_event_value = res_q.second_event_value;
  assign res_o.synth_mode_out     = res_q.synth_mode_out;
  assign res_o.lfo_select_out     = res_q.lfo_select_out;

endmodule

>>> src/amsd_checker.sv
`include "analog_mux_scanner_deadband_top_macros.svh"

module amsd_checker import amsd_pkg::*; (
  input logic                  clk_i,
  input logic                  rst_ni,
  input logic                  res_valid_i,
  input logic                  res_ready_i,
  input logic [CHSEL_W-1:0]    scanned_channel_i,
  input logic [CHSEL_W-1:0]    next_address_i,
  input logic                  first_event_valid_i,
  input logic [VALUE_BITS-1:0] first_event_value_i,
  input logic                  second_event_valid_i,
  input logic [VALUE_BITS-1:0] second_event_value_i,
  input logic                  synth_mode_out_i,
  input logic [1:0]            lfo_select_out_i
);

  // A held result keeps every field.
  `AMSD_ASSERT_NEXT(a_res_hold, res_valid_i && !res_ready_i, res_valid_i && $stable(scanned_channel_i) && $stable(next_address_i) && $stable(first_event_valid_i) && $stable(first_event_value_i) && $stable(second_event_valid_i) && $stable(second_event_value_i) && $stable(synth_mode_out_i) && $stable(lfo_select_out_i), "result changed while stalled")

  // The scan either steps to the following channel or wraps to zero.
  `AMSD_ASSERT_NOW(a_next_addr, res_valid_i, (next_address_i == 4'd0) || (next_address_i == scanned_channel_i + 4'd1), "next address neither wraps nor steps by one")

  // An event value without its event is always zero.
  `AMSD_ASSERT_NOW(a_first_quiet, res_valid_i && !first_event_valid_i, first_event_value_i == '0, "mux one value without event")

  `AMSD_ASSERT_NOW(a_second_quiet, res_valid_i && !second_event_valid_i, second_event_value_i == '0, "mux two value without event")

endmodule

bind analog_mux_scanner_deadband_top amsd_checker u_amsd_checker (
  .clk_i                (clk_i),
  .rst_ni               (rst_ni),
  .res_valid_i          (res_o.valid),
  .res_ready_i          (res_o.ready),
  .scanned_channel_i    (res_o.scanned_channel),
  .next_address_i       (res_o.next_address),
  .first_event_valid_i  (res_o.first_event_valid),
  .first_event_value_i  (res_o.first_event_value),
  .second_event_valid_i (res_o.second_event_valid),
  .second_event_value_i (res_o.second_event_value),
  .synth_mode_out_i     (res_o.synth_mode_out),
  .lfo_select_out_i     (res_o.lfo_select_out)
);

>>> verif/tb_analog_mux_scanner_deadband_top.sv
module tb_analog_mux_scanner_deadband_top import amsd_pkg::*; ;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int unsigned CHANNELS = CHANNELS_DEF;
  localparam int unsigned ADC_BITS = ADC_BITS_DEF;
  localparam int unsigned ADC_MAX  = (1 << ADC_BITS) - 1;

  // A request passes the input and the result register, so quiet cycles with
  // nothing outstanding mean the pipeline is empty and registers may change.
  localparam int unsigned SETTLE_CYCLES = 4;
  localparam int unsigned DRAIN_CYCLES  = 10;
  localparam int unsigned LIMIT_CYCLES  = 200000;
  localparam int unsigned PRINT_LIMIT   = 40;
  localparam int unsigned SCAN_PHASES   = 10;
  localparam int unsigned PHASE_STEPS   = 70;

  // The sender works through a list of these. A register write and an idle
  // wait both hold the sender until every outstanding result has come back.
  typedef enum logic [1:0] {
    SCAN_STEP,
    REG_WRITE,
    WAIT_IDLE
  } stim_kind_e;

  typedef struct packed {
    stim_kind_e            kind;
    logic [ADC_BITS-1:0]   first;
    logic [ADC_BITS-1:0]   second;
    cfg_idx_e              reg_idx;
    logic [CFG_DATA_W-1:0] reg_data;
  } stim_t;

  logic clk_i = 1'b0;
  logic rst_ni;

  amsd_cfg_if                        cfg_bus ();
  amsd_req_if #(.ADC_BITS(ADC_BITS)) scan_req ();
  amsd_res_if                        scan_res ();

  analog_mux_scanner_deadband_top #(
    .CHANNELS(CHANNELS),
    .ADC_BITS(ADC_BITS)
  ) uut (
    .clk_i (clk_i),
    .rst_ni(rst_ni),
    .cfg_i (cfg_bus),
    .req_i (scan_req),
    .res_o (scan_res)
  );

  always begin
    #5 clk_i = 1'b1;
    #5 clk_i = 1'b0;
  end

  stim_t   pending_stim[$];
  result_t scan_expect[$];

  int unsigned error_count  = 0;
  int unsigned results_seen = 0;
  int unsigned cycle_count  = 0;

  // Shadow copy of the scanner: configuration, scan position, both
  // last-value stores and the switch state.
  cfg_t                shadow_cfg;
  logic [CHSEL_W-1:0]  scan_pos;
  logic [ADC_BITS-1:0] first_store [CHANNELS];
  logic [ADC_BITS-1:0] second_store[CHANNELS];
  logic                left_low;
  logic                right_low;
  logic                mode_low;
  lfo_sel_e            lfo_pos;

  // Sender pacing state.
  int unsigned burst_left   = 8;
  int unsigned gap_left     = 0;
  int unsigned idle_cycles  = 0;

  // Receiver stall pattern: one bit per cycle, chosen by stall_tick[3:0] and
  // redrawn as stall_tick[7:0] wraps. A set bit holds off results that cycle.
  logic [15:0] stall_pattern = 16'h0000;
  int unsigned stall_tick    = 0;

  task automatic report_mismatch(string msg);
    error_count++;
    if (error_count <= PRINT_LIMIT) begin
      $display("[%0t] mismatch: %s", $realtime, msg);
    end
  endtask

  task automatic check_field(string field, logic [7:0] got, logic [7:0] want);
    if (got !== want) begin
      report_mismatch($sformatf("result %0d %s: got %0h, expected %0h",
                                results_seen, field, got, want));
    end
  endtask

  // A reading counts only when it moves strictly more than the deadband away
  // from what the store holds for this channel.
  function automatic bit exceeds_deadband(logic [ADC_BITS-1:0] reading,
                                          logic [ADC_BITS-1:0] stored);
    int unsigned diff;
    diff = (reading > stored) ? reading - stored : stored - reading;
    return diff > shadow_cfg.deadband;
  endfunction

  // Works out the result of one scan step and advances the shadow state.
  function automatic result_t predict_scan(logic [ADC_BITS-1:0] first,
                                           logic [ADC_BITS-1:0] second);
    int unsigned           ch;
    int unsigned           span1;
    int unsigned           span2;
    int unsigned           nxt;
    logic [VALUE_BITS-1:0] level;
    result_t               r;
    r     = '0;
    ch    = scan_pos;
    span1 = shadow_cfg.mux1_count;
    span2 = shadow_cfg.mux2_count;
    // A zero mux one count still scans channel 0; counts past the array
    // size are clipped to it. A zero mux two count turns mux two off.
    if (span1 == 0) span1 = 1;
    if (span1 > CHANNELS) span1 = CHANNELS;
    if (span2 > CHANNELS) span2 = CHANNELS;

    // Mux one: the switch roles win over the event mask, and the mode switch
    // wins over the left contact, which wins over the right contact.
    if (ch < span1 && exceeds_deadband(first, first_store[ch])) begin
      level           = VALUE_BITS'(first >> (ADC_BITS - VALUE_BITS));
      first_store[ch] = first;
      if (ch == shadow_cfg.mode_ch) begin
        mode_low = (level < LOW_LEVEL);
      end else if (ch == shadow_cfg.lfo_left_ch) begin
        left_low = (level < LOW_LEVEL);
      end else if (ch == shadow_cfg.lfo_right_ch) begin
        right_low = (level < LOW_LEVEL);
      end else if (shadow_cfg.mux1_mask[ch]) begin
        r.first_event_valid = 1'b1;
        r.first_event_value = level;
      end
      // The select follows the contacts only on an accepted mux one reading.
      if (left_low && !right_low) begin
        lfo_pos = LFO_LEFT;
      end else if (!left_low && right_low) begin
        lfo_pos = LFO_RIGHT;
      end else begin
        lfo_pos = LFO_MIDDLE;
      end
    end

    // Mux two only ever produces events.
    if (ch < span2 && exceeds_deadband(second, second_store[ch])) begin
      second_store[ch] = second;
      if (shadow_cfg.mux2_mask[ch]) begin
        r.second_event_valid = 1'b1;
        r.second_event_value = VALUE_BITS'(second >> (ADC_BITS - VALUE_BITS));
      end
    end

    // The scan wraps at the mux one count; a position left beyond a lowered
    // count was skipped above and falls back to channel 0 here.
    nxt = ch + 1;
    if (nxt >= span1) nxt = 0;
    scan_pos = CHSEL_W'(nxt);

    r.scanned_channel = CHSEL_W'(ch);
    r.next_address    = CHSEL_W'(nxt);
    r.synth_mode_out  = mode_low;
    r.lfo_select_out  = lfo_pos;
    return r;
  endfunction

  task automatic push_step(int unsigned first, int unsigned second);
    stim_t s;
    s        = '0;
    s.kind   = SCAN_STEP;
    s.first  = ADC_BITS'(first);
    s.second = ADC_BITS'(second);
    pending_stim.push_back(s);
  endtask

  task automatic push_write(cfg_idx_e idx, int unsigned value);
    stim_t s;
    s          = '0;
    s.kind     = REG_WRITE;
    s.reg_idx  = idx;
    s.reg_data = CFG_DATA_W'(value);
    pending_stim.push_back(s);
  endtask

  // Readings are either anywhere in range, pinned to an end of the range, or
  // jittered around a per-channel level by a little more than the deadband so
  // that both accepted and rejected readings turn up.
  function automatic int unsigned pick_reading(int level, int db);
    int v;
    case ($urandom_range(0, 9))
      0, 1, 2, 3: v = int'($urandom_range(0, ADC_MAX));
      8:          v = 0;
      9:          v = ADC_MAX;
      default:    v = level + int'($urandom_range(0, 2 * db + 6)) - (db + 3);
    endcase
    if (v < 0) v = 0;
    if (v > int'(ADC_MAX)) v = ADC_MAX;
    return v;
  endfunction

  // Sender. At each edge it first books what the block took at that edge,
  // then decides what to present next. Each valid gets one assignment per
  // edge, so a request that follows directly keeps valid high throughout.
  always @(posedge clk_i) begin
    stim_t head;
    logic  next_scan_valid;
    logic  next_cfg_valid;
    if (rst_ni) begin
      if (scan_req.valid && scan_req.ready) begin
        scan_expect.push_back(predict_scan(scan_req.adc_first, scan_req.adc_second));
        void'(pending_stim.pop_front());
        if (burst_left > 0) burst_left--;
        if (burst_left == 0) begin
          // A new burst: often no gap at all, sometimes a long run.
          gap_left   = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 8);
          burst_left = ($urandom_range(0, 4) == 0) ? $urandom_range(40, 80)
                                                   : $urandom_range(1, 24);
        end
      end
      if (cfg_bus.valid && cfg_bus.ready) begin
        case (cfg_idx_e'(cfg_bus.index))
          CFG_MUX1_COUNT: shadow_cfg.mux1_count   = cfg_bus.data[COUNT_W-1:0];
          CFG_MUX2_COUNT: shadow_cfg.mux2_count   = cfg_bus.data[COUNT_W-1:0];
          CFG_MUX1_MASK:  shadow_cfg.mux1_mask    = cfg_bus.data[MASK_W-1:0];
          CFG_MUX2_MASK:  shadow_cfg.mux2_mask    = cfg_bus.data[MASK_W-1:0];
          CFG_MODE_CH:    shadow_cfg.mode_ch      = cfg_bus.data[CHSEL_W-1:0];
          CFG_LFO_LEFT:   shadow_cfg.lfo_left_ch  = cfg_bus.data[CHSEL_W-1:0];
          CFG_LFO_RIGHT:  shadow_cfg.lfo_right_ch = cfg_bus.data[CHSEL_W-1:0];
          CFG_DEADBAND:   shadow_cfg.deadband     = cfg_bus.data[DEADBAND_W-1:0];
          default: ;
        endcase
        void'(pending_stim.pop_front());
      end

      // Count quiet cycles: nothing requested is still owed by the block.
      if (scan_expect.size() == 0) begin
        idle_cycles++;
      end else begin
        idle_cycles = 0;
      end

      next_scan_valid = 1'b0;
      next_cfg_valid  = 1'b0;
      if (pending_stim.size() != 0) begin
        head = pending_stim[0];
        case (head.kind)
          SCAN_STEP: begin
            if (gap_left > 0) begin
              gap_left--;
            end else begin
              next_scan_valid     = 1'b1;
              scan_req.adc_first  <= head.first;
              scan_req.adc_second <= head.second;
            end
          end
          REG_WRITE: begin
            if (idle_cycles >= SETTLE_CYCLES) begin
              next_cfg_valid = 1'b1;
              cfg_bus.index  <= head.reg_idx;
              cfg_bus.data   <= head.reg_data;
            end
          end
          default: begin
            if (idle_cycles >= SETTLE_CYCLES) void'(pending_stim.pop_front());
          end
        endcase
      end
      scan_req.valid <= next_scan_valid;
      cfg_bus.valid  <= next_cfg_valid;
    end
  end

  // Receiver. Every result taken is checked field by field against the oldest
  // prediction; ready then follows the current stall pattern.
  always @(posedge clk_i) begin
    result_t want;
    if (rst_ni) begin
      if (scan_res.valid && scan_res.ready) begin
        if (scan_expect.size() == 0) begin
          report_mismatch($sformatf("result %0d arrived with nothing expected",
                                    results_seen));
        end else begin
          want = scan_expect.pop_front();
          check_field("scanned_channel", scan_res.scanned_channel, want.scanned_channel);
          check_field("next_address", scan_res.next_address, want.next_address);
          check_field("first_event_valid", scan_res.first_event_valid,
                      want.first_event_valid);
          check_field("first_event_value", scan_res.first_event_value,
                      want.first_event_value);
          check_field("second_event_valid", scan_res.second_event_valid,
                      want.second_event_valid);
          check_field("second_event_value", scan_res.second_event_value,
                      want.second_event_value);
          check_field("synth_mode_out", scan_res.synth_mode_out, want.synth_mode_out);
          check_field("lfo_select_out", scan_res.lfo_select_out, want.lfo_select_out);
        end
        results_seen++;
      end

      stall_tick++;
      if (stall_tick[7:0] == 8'd0) begin
        // A third of the windows run without any stall. The others keep at
        // least one ready slot so the result channel always drains.
        if ($urandom_range(0, 2) == 0) begin
          stall_pattern = 16'h0000;
        end else begin
          stall_pattern = 16'($urandom_range(0, 16'hFFFF));
          stall_pattern[$urandom_range(0, 15)] = 1'b0;
        end
      end
      scan_res.ready <= !stall_pattern[stall_tick[3:0]];
    end
  end

  // Watchdog against a hung handshake.
  always @(posedge clk_i) begin
    cycle_count++;
    if (cycle_count > LIMIT_CYCLES) begin
      $display("CHECKS FAILED");
      $finish;
    end
  end

  initial begin
    int bases[CHANNELS];
    int db;
    int unsigned hold_at;

    // Every input of the block is known from time zero on.
    rst_ni              = 1'b0;
    scan_req.valid      = 1'b0;
    scan_req.adc_first  = '0;
    scan_req.adc_second = '0;
    cfg_bus.valid       = 1'b0;
    cfg_bus.index       = CFG_MUX1_COUNT;
    cfg_bus.data        = '0;
    scan_res.ready      = 1'b0;

    // Shadow state as the block comes out of reset.
    shadow_cfg = CFG_RESET;
    scan_pos   = '0;
    for (int i = 0; i < CHANNELS; i++) begin
      first_store[i]  = '0;
      second_store[i] = '0;
    end
    left_low  = MODE_RESET.lfo_left;
    right_low = MODE_RESET.lfo_right;
    mode_low  = MODE_RESET.synth_mode;
    lfo_pos   = MODE_RESET.lfo_sel;

    // Directed part. One step under the reset settings, with no event enabled.
    push_step(ADC_MAX, ADC_MAX);

    // Every mask bit set, no deadband, both counts above the array size.
    push_write(CFG_MUX1_COUNT, 31);
    push_write(CFG_MUX2_COUNT, 31);
    push_write(CFG_MUX1_MASK, 16'hFFFF);
    push_write(CFG_MUX2_MASK, 16'hFFFF);
    push_write(CFG_MODE_CH, 4);
    push_write(CFG_LFO_LEFT, 5);
    push_write(CFG_LFO_RIGHT, 6);
    push_write(CFG_DEADBAND, 0);
    push_step(0, 1);          // mux one unchanged at zero, mux two moves by one
    push_step(8, ADC_MAX);
    push_step(ADC_MAX, 0);
    push_step(511, 5);        // mode switch just below the low level
    push_step(100, 5);        // left contact low: select goes left
    push_step(100, 7);        // right contact low too: back to middle
    for (int i = 7; i < CHANNELS; i++) begin
      push_step(i * 61, ADC_MAX - i * 57);
    end

    // Widest deadband, all roles on channel 0 over a set mask bit, and mux
    // two cut down to three channels.
    push_write(CFG_MUX2_COUNT, 3);
    push_write(CFG_DEADBAND, 255);
    push_write(CFG_MODE_CH, 0);
    push_write(CFG_LFO_LEFT, 0);
    push_write(CFG_LFO_RIGHT, 0);
    push_write(CFG_MUX1_MASK, 16'h0001);
    push_step(0, 800);        // mode wins; mux two stays inside the deadband
    push_step(300, ADC_MAX);
    push_step(263, ADC_MAX);  // a change of exactly the deadband is ignored
    push_step(ADC_MAX, ADC_MAX); // channel 3 lies beyond the mux two count

    // Zero counts: mux one scans channel 0 only and mux two is off. The scan
    // sits beyond the new count first, so that step skips mux one.
    push_write(CFG_MUX1_COUNT, 0);
    push_write(CFG_MUX2_COUNT, 0);
    push_step(0, ADC_MAX);
    push_step(ADC_MAX, 0);
    push_step(ADC_MAX, ADC_MAX);

    // Random phases, each under fresh settings.
    for (int p = 0; p < SCAN_PHASES; p++) begin
      case ($urandom_range(0, 5))
        0:       push_write(CFG_MUX1_COUNT, 0);
        1:       push_write(CFG_MUX1_COUNT, 1);
        2:       push_write(CFG_MUX1_COUNT, 16);
        3:       push_write(CFG_MUX1_COUNT, 31);
        default: push_write(CFG_MUX1_COUNT, $urandom_range(1, 31));
      endcase
      case ($urandom_range(0, 4))
        0:       push_write(CFG_MUX2_COUNT, 0);
        1:       push_write(CFG_MUX2_COUNT, 31);
        2:       push_write(CFG_MUX2_COUNT, 16);
        default: push_write(CFG_MUX2_COUNT, $urandom_range(0, 31));
      endcase
      case ($urandom_range(0, 3))
        0:       push_write(CFG_MUX1_MASK, 16'hFFFF);
        1:       push_write(CFG_MUX1_MASK, 0);
        default: push_write(CFG_MUX1_MASK, $urandom_range(0, 16'hFFFF));
      endcase
      case ($urandom_range(0, 3))
        0:       push_write(CFG_MUX2_MASK, 16'hFFFF);
        1:       push_write(CFG_MUX2_MASK, 0);
        default: push_write(CFG_MUX2_MASK, $urandom_range(0, 16'hFFFF));
      endcase
      // Roles crowded onto a few channels now and then, so they collide.
      if ($urandom_range(0, 2) == 0) begin
        push_write(CFG_MODE_CH, $urandom_range(0, 2));
        push_write(CFG_LFO_LEFT, $urandom_range(0, 2));
        push_write(CFG_LFO_RIGHT, $urandom_range(0, 2));
      end else begin
        push_write(CFG_MODE_CH, $urandom_range(0, 15));
        push_write(CFG_LFO_LEFT, $urandom_range(0, 15));
        push_write(CFG_LFO_RIGHT, $urandom_range(0, 15));
      end
      case ($urandom_range(0, 4))
        0:       db = 0;
        1:       db = 255;
        default: db = $urandom_range(0, 40);
      endcase
      push_write(CFG_DEADBAND, db);

      for (int i = 0; i < CHANNELS; i++) begin
        bases[i] = $urandom_range(0, ADC_MAX);
      end
      // Somewhere inside each phase the sender holds off until the block
      // has returned everything it owes.
      hold_at = $urandom_range(5, PHASE_STEPS - 5);
      for (int j = 0; j < PHASE_STEPS; j++) begin
        if (j == hold_at) begin
          pending_stim.push_back('{kind: WAIT_IDLE, reg_idx: CFG_MUX1_COUNT, default: '0});
        end
        push_step(pick_reading(bases[j % CHANNELS], db),
                  pick_reading(bases[(j + 5) % CHANNELS], db));
      end
    end

    // Release reset at an edge, once, and never assert it again.
    repeat (12) @(posedge clk_i);
    rst_ni <= 1'b1;

    while (pending_stim.size() != 0 || scan_expect.size() != 0) @(posedge clk_i);
    repeat (DRAIN_CYCLES) @(posedge clk_i);

    if (error_count == 0) begin
      $display("ALL CHECKS PASSED");
    end else begin
      $display("CHECKS FAILED");
    end
    $finish;
  end

endmodule

>>> files.f
+incdir+src
src/amsd_pkg.sv
src/amsd_if.sv
src/amsd_cfg_regs.sv
src/amsd_step.sv
src/analog_mux_scanner_deadband_top.sv
src/amsd_checker.sv
verif/tb_analog_mux_scanner_deadband_top.sv
